// File: hdl/frp_pkg.sv
// Shared constants and types for the factor rating predictor.
package frp_pkg;

    // Default sizes of the factor stores
    localparam int ROWS_DEF     = 1024;
    localparam int COLS_DEF     = 1024;
    localparam int MAX_RANK_DEF = 16;

    // Field widths
    localparam int FUNC_W   = 2;
    localparam int IDX_W    = 10;
    localparam int COMP_W   = 4;
    localparam int FACTOR_W = 16;
    localparam int RATING_W = 16;
    localparam int KIND_W   = 2;
    localparam int RANK_W   = 7;    // holds rank values up to 127
    localparam int CFG_AW   = 2;
    localparam int CFG_DW   = 16;
    localparam int PROD_W   = 2 * FACTOR_W;
    localparam int FRAC_W   = 12;
    localparam int IDX_CMP_W = 17;  // wide enough to compare against 65536

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_WR_ROW  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WR_COL  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_PREDICT = 2'd2;

    // Clamp outcome codes
    localparam logic [KIND_W-1:0] KIND_IN_RANGE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ZERO     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ONE      = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_RANK = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_MEAN = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_MIN  = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_MAX  = 2'd3;

    // Control of one prediction as it enters the dot-product unit
    typedef struct packed {
        logic              valid;
        logic              row_ok;
        logic              col_ok;
        logic [RANK_W-1:0] rank;
    } t_pred_ctl;

endpackage

// File: hdl/frp_ram.sv
// Generic simple dual-port RAM with a registered read.
module frp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: hdl/frp_store.sv
// One factor store: a bank of RAM per component, read as a whole factor row.
module frp_store #(
    parameter int DEPTH    = frp_pkg::ROWS_DEF,
    parameter int MAX_RANK = frp_pkg::MAX_RANK_DEF,
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [AW-1:0]                         i_addr,
    input  logic [frp_pkg::COMP_W-1:0]            i_comp,
    input  logic [frp_pkg::FACTOR_W-1:0]          i_wdata,
    output logic [MAX_RANK*frp_pkg::FACTOR_W-1:0] o_row
);

    for (genvar k = 0; k < MAX_RANK; k++) begin : g_bank
        logic bank_we;

        assign bank_we = i_we && (frp_pkg::RANK_W'(i_comp) == frp_pkg::RANK_W'(k));

        frp_ram #(
            .WIDTH (frp_pkg::FACTOR_W),
            .DEPTH (DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (bank_we),
            .i_waddr (i_addr),
            .i_wdata (i_wdata),
            .i_raddr (i_addr),
            .o_rdata (o_row[k*frp_pkg::FACTOR_W +: frp_pkg::FACTOR_W])
        );
    end

endmodule

// File: hdl/frp_dot.sv
// Dot-product unit: one multiplier per component and a registered adder tree.
module frp_dot #(
    parameter int MAX_RANK = frp_pkg::MAX_RANK_DEF,
    localparam int LVL     = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 0,
    localparam int SUM_W   = frp_pkg::PROD_W + LVL
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  frp_pkg::t_pred_ctl                    i_ctl,
    input  logic [MAX_RANK*frp_pkg::FACTOR_W-1:0] i_row,
    input  logic [MAX_RANK*frp_pkg::FACTOR_W-1:0] i_col,
    output logic                                  o_valid,
    output logic signed [SUM_W-1:0]               o_sum
);

    localparam int N = 1 << LVL;

    // Heap-ordered tree: node i has children 2i+1 and 2i+2, leaves from N-1.
    logic signed [SUM_W-1:0] r_node [0:2*N-2];
    logic [LVL:0]            r_vld;

    for (genvar k = 0; k < N; k++) begin : g_lane
        if (k < MAX_RANK) begin : g_mul
            logic                                used;
            logic signed [frp_pkg::FACTOR_W-1:0] a;
            logic signed [frp_pkg::FACTOR_W-1:0] b;

            assign used = frp_pkg::RANK_W'(k) < i_ctl.rank;
            assign a = (used && i_ctl.row_ok) ?
                       i_row[k*frp_pkg::FACTOR_W +: frp_pkg::FACTOR_W] : '0;
            assign b = (used && i_ctl.col_ok) ?
                       i_col[k*frp_pkg::FACTOR_W +: frp_pkg::FACTOR_W] : '0;

            always_ff @(posedge i_clk) begin
                r_node[N-1+k] <= SUM_W'(a * b);
            end
        end else begin : g_pad
            always_ff @(posedge i_clk) begin
                r_node[N-1+k] <= '0;
            end
        end
    end

    for (genvar i = 0; i < N - 1; i++) begin : g_add
        always_ff @(posedge i_clk) begin
            r_node[i] <= r_node[2*i+1] + r_node[2*i+2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_ctl.valid;
        end
    end

    for (genvar l = 1; l <= LVL; l++) begin : g_vld
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[l] <= 1'b0;
            end else begin
                r_vld[l] <= r_vld[l-1];
            end
        end
    end

    assign o_valid = r_vld[LVL];
    assign o_sum   = r_node[0];

endmodule

// File: hdl/factor_rating_predictor_unit.sv
// Top level of the factor rating predictor: command decode, stores, clamp and rating map.
//
//  Channel  | Direction | Handshake                  | Beat carries
//  ---------+-----------+----------------------------+------------------------------------
//  command  | in        | i_start high, o_busy low   | func, row/col index, component, value
//  result   | out       | o_valid for one cycle      | rating, clamp_kind
//  config   | in        | i_cfg_we high              | register index, write data
//
//  A command beat is taken every cycle; o_busy is never raised.
//  A predict passes a RAM read register, a multiply register, one register per
//  adder-tree level, then clamp, scale and output registers. Writes complete in
//  the cycle they are taken. Reset sets rank to 1, mean and min to 0 and max to
//  all ones, and clears the pipeline valids; store contents are undefined until
//  written. The result side cannot stall.
module factor_rating_predictor_unit #(
    parameter int ROWS     = frp_pkg::ROWS_DEF,
    parameter int COLS     = frp_pkg::COLS_DEF,
    parameter int MAX_RANK = frp_pkg::MAX_RANK_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic [frp_pkg::FUNC_W-1:0]          i_func,
    input  logic [frp_pkg::IDX_W-1:0]           i_row_index,
    input  logic [frp_pkg::IDX_W-1:0]           i_col_index,
    input  logic [frp_pkg::COMP_W-1:0]          i_component,
    input  logic signed [frp_pkg::FACTOR_W-1:0] i_factor_value,
    input  logic                                i_cfg_we,
    input  logic [frp_pkg::CFG_AW-1:0]          i_cfg_addr,
    input  logic [frp_pkg::CFG_DW-1:0]          i_cfg_wdata,
    output logic                                o_valid,
    output logic [frp_pkg::RATING_W-1:0]        o_rating,
    output logic [frp_pkg::KIND_W-1:0]          o_clamp_kind
);

    localparam int RAW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CAW   = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int LVL   = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 0;
    localparam int SUM_W = frp_pkg::PROD_W + LVL;
    localparam int S_W   = SUM_W + 1;
    localparam int C_W   = frp_pkg::FRAC_W + 1;
    localparam int D_W   = frp_pkg::RATING_W + 1;
    localparam int P_W   = C_W + 1 + D_W;
    localparam int FW    = frp_pkg::FACTOR_W;

    // Configuration registers
    logic [4:0]                           r_rank;
    logic signed [frp_pkg::CFG_DW-1:0]    r_mean;
    logic [frp_pkg::RATING_W-1:0]         r_min;
    logic [frp_pkg::RATING_W-1:0]         r_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank <= 5'd1;
            r_mean <= '0;
            r_min  <= '0;
            r_max  <= '1;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                frp_pkg::CFG_RANK: r_rank <= i_cfg_wdata[4:0];
                frp_pkg::CFG_MEAN: r_mean <= i_cfg_wdata;
                frp_pkg::CFG_MIN:  r_min  <= i_cfg_wdata;
                frp_pkg::CFG_MAX:  r_max  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Command decode
    logic                               accept;
    logic                               row_ok;
    logic                               col_ok;
    logic                               comp_ok;
    logic                               row_we;
    logic                               col_we;
    logic [frp_pkg::IDX_W+RAW-1:0]      row_ext;
    logic [frp_pkg::IDX_W+CAW-1:0]      col_ext;
    logic [frp_pkg::RANK_W-1:0]         rank_sat;
    frp_pkg::t_pred_ctl                 n_ctl;
    frp_pkg::t_pred_ctl                 r_ctl;

    assign o_busy  = 1'b0;
    assign accept  = i_start && !o_busy;
    assign row_ok  = frp_pkg::IDX_CMP_W'(i_row_index) < frp_pkg::IDX_CMP_W'(ROWS);
    assign col_ok  = frp_pkg::IDX_CMP_W'(i_col_index) < frp_pkg::IDX_CMP_W'(COLS);
    assign comp_ok = frp_pkg::RANK_W'(i_component) < frp_pkg::RANK_W'(MAX_RANK);
    assign row_we  = accept && (i_func == frp_pkg::FUNC_WR_ROW) && row_ok && comp_ok;
    assign col_we  = accept && (i_func == frp_pkg::FUNC_WR_COL) && col_ok && comp_ok;
    assign row_ext = {{RAW{1'b0}}, i_row_index};
    assign col_ext = {{CAW{1'b0}}, i_col_index};

    // Ranks above the store width saturate.
    assign rank_sat = (frp_pkg::RANK_W'(r_rank) > frp_pkg::RANK_W'(MAX_RANK)) ?
                      frp_pkg::RANK_W'(MAX_RANK) : frp_pkg::RANK_W'(r_rank);

    always_comb begin
        n_ctl.valid  = accept && (i_func == frp_pkg::FUNC_PREDICT);
        n_ctl.row_ok = row_ok;
        n_ctl.col_ok = col_ok;
        n_ctl.rank   = rank_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else begin
            r_ctl.valid <= n_ctl.valid;
        end
        r_ctl.row_ok <= n_ctl.row_ok;
        r_ctl.col_ok <= n_ctl.col_ok;
        r_ctl.rank   <= n_ctl.rank;
    end

    // Factor stores
    logic [MAX_RANK*FW-1:0] row_data;
    logic [MAX_RANK*FW-1:0] col_data;

    frp_store #(
        .DEPTH    (ROWS),
        .MAX_RANK (MAX_RANK)
    ) u_row_store (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_addr  (row_ext[RAW-1:0]),
        .i_comp  (i_component),
        .i_wdata (i_factor_value),
        .o_row   (row_data)
    );

    frp_store #(
        .DEPTH    (COLS),
        .MAX_RANK (MAX_RANK)
    ) u_col_store (
        .i_clk   (i_clk),
        .i_we    (col_we),
        .i_addr  (col_ext[CAW-1:0]),
        .i_comp  (i_component),
        .i_wdata (i_factor_value),
        .o_row   (col_data)
    );

    // Dot product
    logic                    dot_valid;
    logic signed [SUM_W-1:0] dot_sum;

    frp_dot #(
        .MAX_RANK (MAX_RANK)
    ) u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_ctl),
        .i_row   (row_data),
        .i_col   (col_data),
        .o_valid (dot_valid),
        .o_sum   (dot_sum)
    );

    // Add the mean and clamp to the range zero to one (sum is signed Q12.24 for MAX_RANK 16).
    logic signed [S_W-1:0]        s_sum;
    logic                         s_neg;
    logic                         s_over;
    logic [C_W-1:0]               n_c;
    logic [frp_pkg::KIND_W-1:0]   n_kind;
    logic [C_W-1:0]               r_c;
    logic [frp_pkg::KIND_W-1:0]   r_kind;
    logic                         r_c_vld;

    assign s_sum = {{(S_W-SUM_W){dot_sum[SUM_W-1]}}, dot_sum}
                 + {{(S_W-FW-frp_pkg::FRAC_W){r_mean[FW-1]}}, r_mean, {frp_pkg::FRAC_W{1'b0}}};
    assign s_neg  = s_sum[S_W-1];
    assign s_over = !s_neg && ((|s_sum[S_W-2:25]) || (s_sum[24] && (|s_sum[23:0])));

    always_comb begin
        if (s_neg) begin
            n_c    = '0;
            n_kind = frp_pkg::KIND_ZERO;
        end else if (s_over) begin
            n_c    = C_W'(1 << frp_pkg::FRAC_W);
            n_kind = frp_pkg::KIND_ONE;
        end else begin
            n_c    = s_sum[24:12];
            n_kind = frp_pkg::KIND_IN_RANGE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= dot_valid;
        end
        r_c    <= n_c;
        r_kind <= n_kind;
    end

    // Scale onto the rating range.
    logic signed [D_W-1:0]        delta;
    logic signed [P_W-1:0]        r_prod;
    logic [frp_pkg::KIND_W-1:0]   r_p_kind;
    logic                         r_p_vld;

    assign delta = signed'({1'b0, r_max}) - signed'({1'b0, r_min});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else begin
            r_p_vld <= r_c_vld;
        end
        r_prod   <= P_W'(signed'({1'b0, r_c}) * delta);
        r_p_kind <= r_kind;
    end

    // The arithmetic shift floors a negative product, which a downward mapping needs.
    logic signed [P_W-1:0] q;

    assign q = r_prod >>> frp_pkg::FRAC_W;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_p_vld;
        end
        o_rating     <= r_min + q[frp_pkg::RATING_W-1:0];
        o_clamp_kind <= r_p_kind;
    end

endmodule
